// ===== rtl/core/addressed_command_frame_parser_assert.svh =====
// assertion macros shared by the frame parser rtl
// needs clk and rst in the scope of each use
`ifndef ADDRESSED_COMMAND_FRAME_PARSER_ASSERT_SVH
`define ADDRESSED_COMMAND_FRAME_PARSER_ASSERT_SVH

`ifndef SYNTHESIS
`define ACFP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ACFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ACFP_ASSERT_NOW(lbl, ante, cons, msg)
`define ACFP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/core/acfp_pkg.sv =====
// shared types and constants of the addressed command frame parser
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package acfp_pkg;

  localparam int BYTE_W            = 8;
  localparam int NUM_OUT           = 4;
  localparam int PAYLOAD_BYTES_DEF = 4;

  localparam logic [BYTE_W-1:0] START_FIRST = 8'hAA;
  localparam logic [BYTE_W-1:0] START_SECOND = 8'h55;
  localparam logic [BYTE_W-1:0] END_FIRST = 8'h55;
  localparam logic [BYTE_W-1:0] END_SECOND = 8'hAA;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_ADDR = 2'd1,
    PH_DATA = 2'd2,
    PH_END  = 2'd3
  } phase_t;

  typedef struct packed {
    logic                             good;
    logic [NUM_OUT-1:0][BYTE_W-1:0]   payload;
  } result_t;

  typedef struct packed {
    logic closing_byte;
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/core/acfp_deframer.sv =====
// frame hunting state machine and payload capture
// depends on acfp_pkg and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none

`include "addressed_command_frame_parser_assert.svh"

module acfp_deframer #(
  parameter int PAYLOAD_BYTES = acfp_pkg::PAYLOAD_BYTES_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        step,
  input  wire logic [acfp_pkg::BYTE_W-1:0] rx_byte,
  input  wire logic [acfp_pkg::BYTE_W-1:0] node_address,
  output acfp_pkg::result_t                result,
  output acfp_pkg::status_t                status
);

  localparam int CNT_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PAYLOAD_BYTES - 1);

  acfp_pkg::phase_t phase, phase_next;
  logic [acfp_pkg::BYTE_W-1:0] held_start, held_start_next;
  logic                        start_held, start_held_next;
  logic [CNT_W-1:0]            payload_count, payload_count_next;
  logic [acfp_pkg::BYTE_W-1:0] held_end, held_end_next;
  logic                        end_held, end_held_next;
  logic                        frame_good;
  logic [acfp_pkg::BYTE_W-1:0] payload_store [PAYLOAD_BYTES];

  logic start_match;
  assign start_match = start_held && (held_start == acfp_pkg::START_FIRST)
                       && (rx_byte == acfp_pkg::START_SECOND);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= acfp_pkg::PH_HUNT;
      held_start    <= '0;
      start_held    <= 1'b0;
      payload_count <= '0;
      held_end      <= '0;
      end_held      <= 1'b0;
    end else begin
      phase         <= phase_next;
      held_start    <= held_start_next;
      start_held    <= start_held_next;
      payload_count <= payload_count_next;
      held_end      <= held_end_next;
      end_held      <= end_held_next;
    end
  end

  // next state
  always_comb begin
    phase_next = phase;
    if (step) begin
      unique case (phase)
        acfp_pkg::PH_HUNT: begin
          if (start_match) phase_next = acfp_pkg::PH_ADDR;
        end
        acfp_pkg::PH_ADDR: begin
          phase_next = (rx_byte == node_address) ? acfp_pkg::PH_DATA : acfp_pkg::PH_HUNT;
        end
        acfp_pkg::PH_DATA: begin
          if (payload_count == CNT_LAST) phase_next = acfp_pkg::PH_END;
        end
        acfp_pkg::PH_END: begin
          if (end_held) phase_next = acfp_pkg::PH_HUNT;
        end
        default: phase_next = acfp_pkg::PH_HUNT;
      endcase
    end
  end

  // outputs and datapath
  always_comb begin
    held_start_next    = held_start;
    start_held_next    = start_held;
    payload_count_next = payload_count;
    held_end_next      = held_end;
    end_held_next      = end_held;
    frame_good         = 1'b0;
    if (step) begin
      unique case (phase)
        acfp_pkg::PH_HUNT: begin
          if (start_match) begin
            held_start_next = '0;
            start_held_next = 1'b0;
          end else begin
            held_start_next = rx_byte;
            start_held_next = 1'b1;
          end
        end
        acfp_pkg::PH_ADDR: begin
          if (rx_byte == node_address) payload_count_next = '0;
        end
        acfp_pkg::PH_DATA: begin
          if (payload_count == CNT_LAST) begin
            payload_count_next = '0;
            end_held_next      = 1'b0;
          end else begin
            payload_count_next = payload_count + CNT_W'(1);
          end
        end
        acfp_pkg::PH_END: begin
          if (!end_held) begin
            held_end_next = rx_byte;
            end_held_next = 1'b1;
          end else begin
            held_end_next = '0;
            end_held_next = 1'b0;
            frame_good    = (held_end == acfp_pkg::END_FIRST)
                            && (rx_byte == acfp_pkg::END_SECOND);
          end
        end
        default: ;
      endcase
    end
  end

  for (genvar k = 0; k < PAYLOAD_BYTES; k++) begin : g_store
    always_ff @(posedge clk) begin
      if (step && (phase == acfp_pkg::PH_DATA) && (payload_count == CNT_W'(k))) begin
        payload_store[k] <= rx_byte;
      end
    end
  end

  for (genvar k = 0; k < acfp_pkg::NUM_OUT; k++) begin : g_out
    if (k < PAYLOAD_BYTES) begin : g_byte
      assign result.payload[k] = payload_store[k];
    end else begin : g_zero
      assign result.payload[k] = '0;
    end
  end

  assign result.good          = frame_good;
  assign status.closing_byte  = (phase == acfp_pkg::PH_END) && end_held;

  `ACFP_ASSERT_NOW(a_addr_window_empty, phase == acfp_pkg::PH_ADDR, !start_held, "window not cleared after start marker")
  `ACFP_ASSERT_NEXT(a_data_to_end, step && phase == acfp_pkg::PH_DATA && payload_count == CNT_LAST, phase == acfp_pkg::PH_END && !end_held, "payload end not followed by end marker phase")
  `ACFP_ASSERT_NOW(a_good_only_on_end, frame_good, step && phase == acfp_pkg::PH_END && end_held, "frame reported outside second end byte")

endmodule

`default_nettype wire

// ===== rtl/core/addressed_command_frame_parser.sv =====
// Addressed command frame parser.
// Input channel: in_valid / in_stall carry one received byte rx_byte per
// transfer. The parser hunts for 0xAA 0x55, checks the following byte against
// the node address, captures four payload bytes and checks the end pair 0x55 0xAA.
// Output channel: out_valid / out_stall carry payload_0..payload_3, one
// transfer per good frame. Bad address or bad end pair drops the frame.
// Throughput: one byte per cycle while in_stall is low. Latency: the result
// is valid in the cycle after the transfer of the second end byte.
// Configuration: cfg_write_en / cfg_write_data set the node address; write only
// while the parser is idle.
// Reset (rst, synchronous): hunt state, empty windows, node address 0, no
// result pending.
// Stall: a pending result sits in the output register; input keeps flowing
// and in_stall rises only while the parser waits for the second end byte of
// the next frame and that register is still held by out_stall.
// depends on acfp_pkg, acfp_deframer and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none

`include "addressed_command_frame_parser_assert.svh"

module addressed_command_frame_parser #(
  parameter int PAYLOAD_BYTES = acfp_pkg::PAYLOAD_BYTES_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_write_en,
  input  wire logic [acfp_pkg::BYTE_W-1:0] cfg_write_data,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [acfp_pkg::BYTE_W-1:0] rx_byte,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [acfp_pkg::BYTE_W-1:0]      payload_0,
  output logic [acfp_pkg::BYTE_W-1:0]      payload_1,
  output logic [acfp_pkg::BYTE_W-1:0]      payload_2,
  output logic [acfp_pkg::BYTE_W-1:0]      payload_3
);

  logic [acfp_pkg::BYTE_W-1:0] node_address;
  logic                        step;
  logic                        out_valid_next;
  acfp_pkg::result_t           result;
  acfp_pkg::status_t           status;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_address <= '0;
    end else if (cfg_write_en) begin
      node_address <= cfg_write_data;
    end
  end

  assign in_stall = out_valid && out_stall && status.closing_byte;
  assign step     = in_valid && !in_stall;

  acfp_deframer #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_deframer (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .rx_byte     (rx_byte),
    .node_address(node_address),
    .result      (result),
    .status      (status)
  );

  assign out_valid_next = result.good || (out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (result.good) begin
      payload_0 <= result.payload[0];
      payload_1 <= result.payload[1];
      payload_2 <= result.payload[2];
      payload_3 <= result.payload[3];
    end
  end

  `ACFP_ASSERT_NEXT(a_pending_kept, out_valid && out_stall, out_valid, "pending result lost")
  `ACFP_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall, "input stalled with output free")
  `ACFP_ASSERT_NOW(a_no_overwrite, result.good, !(out_valid && out_stall), "result overwrites pending result")

endmodule

`default_nettype wire
